// File: rtl/sac_pkg.sv
// ============================================================================
// Set-associative cache package
// Shared widths, register codes, controller states and the command and
// status records that pass between the controller and the datapath.
// ============================================================================
package sac_pkg;

    localparam int CNT_W      = 48;
    localparam int ADDR_IN_W  = 48;
    localparam int BLOCK_W    = 5;
    localparam int SETB_W     = 3;
    localparam int WAYB_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [BLOCK_W-1:0] BLOCK_BITS_RST = 5'd6;
    localparam logic [SETB_W-1:0]  SET_BITS_RST   = 3'd4;
    localparam logic [WAYB_W-1:0]  WAY_BITS_RST   = 3'd2;
    localparam logic               USE_LRU_RST    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_BITS,
        CFG_SET_BITS,
        CFG_WAY_BITS,
        CFG_USE_LRU
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic issue;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_way;
        logic out_free;
    } sts_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// File: rtl/sac_ifs.sv
// ============================================================================
// Set-associative cache channel interfaces
// Valid/ready channels for access requests and for access results.
// ============================================================================
interface sac_req_if;
    logic                           valid;
    logic                           ready;
    logic [sac_pkg::ADDR_IN_W-1:0]  address;
    logic                           is_write;

    modport source (output valid, output address, output is_write, input ready);
    modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface sac_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       was_hit;
    logic [sac_pkg::CNT_W-1:0]  hit_total;
    logic [sac_pkg::CNT_W-1:0]  miss_total;
    logic [sac_pkg::CNT_W-1:0]  write_total;

    modport source (output valid, output was_hit, output hit_total, output miss_total,
                    output write_total, input ready);
    modport sink   (input valid, input was_hit, input hit_total, input miss_total,
                    input write_total, output ready);
endinterface

// File: rtl/set_assoc_cache_lru_fifo.sv
// ============================================================================
// Set-associative tag cache with LRU or FIFO replacement
// Looks each access up in its set, fills or replaces on a miss and returns
// the hit flag with saturating hit, miss and write totals.
// ============================================================================
// Each access is set up, scans the 2^w ways of its set, drains and commits,
// where w is the effective way count log2 (way_bits clamped to LINES_LOG2).
// A new access is taken only after the last one commits; the tag and stamp
// memories have one read port, so the scan reads one way of the set per cycle.
// Reset: asynchronous, active low; all lines invalid, counters and the access
// clock zero, block 6, sets 4, ways 2, LRU on; accesses may start at once.
module set_assoc_cache_lru_fifo
#(
    parameter int LINES_LOG2 = 6,
    parameter int ADDR_WIDTH = 48
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_en,
    input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data,
    sac_req_if.sink                         req,
    sac_rsp_if.source                       rsp
);

    // The controller and the datapath talk only through these two records.
    sac_pkg::cmd_t cmd;
    sac_pkg::sts_t sts;

    // The controller owns the request ready: a beat is taken only when no
    // access is in flight, while the result register may still hold the
    // previous beat waiting on the downstream side.
    sac_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the geometry registers, the line stores, the scan
    // logic that tracks the first hit, the first free way and the oldest
    // way, and the result register that decouples the two channels.
    sac_datapath
    #(
        .LINES_LOG2 (LINES_LOG2),
        .ADDR_WIDTH (ADDR_WIDTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_en          (cfg_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_address     (req.address),
        .req_is_write    (req.is_write),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_was_hit     (rsp.was_hit),
        .rsp_hit_total   (rsp.hit_total),
        .rsp_miss_total  (rsp.miss_total),
        .rsp_write_total (rsp.write_total),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

// File: rtl/sac_ctrl.sv
// ============================================================================
// Set-associative cache controller
// Sequences one access through setup, way scan, drain and commit.
// ============================================================================
module sac_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sac_pkg::sts_t   sts,
    output sac_pkg::cmd_t   cmd
);

    sac_pkg::state_t state_reg;
    sac_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sac_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sac_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sac_pkg::ST_SETUP;
                end
            end
            sac_pkg::ST_SETUP:
            begin
                state_next = sac_pkg::ST_SCAN;
            end
            sac_pkg::ST_SCAN:
            begin
                if (sts.last_way)
                begin
                    state_next = sac_pkg::ST_DRAIN;
                end
            end
            sac_pkg::ST_DRAIN:
            begin
                state_next = sac_pkg::ST_COMMIT;
            end
            sac_pkg::ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            sac_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            sac_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            sac_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            sac_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            sac_pkg::ST_COMMIT:
            begin
                cmd.commit = sts.out_free;
            end
        endcase
    end

endmodule

// File: rtl/sac_datapath.sv
// ============================================================================
// Set-associative cache datapath
// Configuration registers, tag and stamp memories, way scan, counters and
// the result register.
// ============================================================================
module sac_datapath
#(
    parameter int LINES_LOG2 = 6,
    parameter int ADDR_WIDTH = 48
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_en,
    input  logic [sac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sac_pkg::ADDR_IN_W-1:0]      req_address,
    input  logic                               req_is_write,
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output logic                               rsp_was_hit,
    output logic [sac_pkg::CNT_W-1:0]          rsp_hit_total,
    output logic [sac_pkg::CNT_W-1:0]          rsp_miss_total,
    output logic [sac_pkg::CNT_W-1:0]          rsp_write_total,
    input  sac_pkg::cmd_t                      cmd,
    output sac_pkg::sts_t                      sts
);

    localparam int LINE_COUNT = 1 << LINES_LOG2;
    localparam int LINE_W     = (LINES_LOG2 > 0) ? LINES_LOG2 : 1;
    localparam int TAG_W      = (ADDR_WIDTH < sac_pkg::ADDR_IN_W) ? ADDR_WIDTH
                                                                   : sac_pkg::ADDR_IN_W;
    localparam int GEO_W      = $clog2(LINES_LOG2 + 8);
    localparam int SH_W       = ((sac_pkg::BLOCK_W > GEO_W) ? sac_pkg::BLOCK_W : GEO_W) + 1;
    localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'(LINE_COUNT - 1);
    localparam logic [GEO_W-1:0]  GEO_LIM   = GEO_W'(LINES_LOG2);

    // Configuration registers.
    logic [sac_pkg::BLOCK_W-1:0] block_bits_reg;
    logic [sac_pkg::SETB_W-1:0]  set_bits_reg;
    logic [sac_pkg::WAYB_W-1:0]  way_bits_reg;
    logic                        use_lru_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bits_reg <= sac_pkg::BLOCK_BITS_RST;
            set_bits_reg   <= sac_pkg::SET_BITS_RST;
            way_bits_reg   <= sac_pkg::WAY_BITS_RST;
            use_lru_reg    <= sac_pkg::USE_LRU_RST;
        end
        else if (cfg_en)
        begin
            unique case (sac_pkg::cfg_idx_t'(cfg_index))
                sac_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data[sac_pkg::BLOCK_W-1:0];
                sac_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_data[sac_pkg::SETB_W-1:0];
                sac_pkg::CFG_WAY_BITS:   way_bits_reg   <= cfg_data[sac_pkg::WAYB_W-1:0];
                sac_pkg::CFG_USE_LRU:    use_lru_reg    <= cfg_data[0];
            endcase
        end
    end

    // Captured access and its geometry.
    logic [TAG_W-1:0]  addr_q_reg;
    logic              wr_q_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [LINE_W-1:0] base_reg;
    logic [LINE_W-1:0] ways_m1_reg;
    logic [LINE_W-1:0] way_cnt_reg;

    logic [GEO_W-1:0]  wb;
    logic [GEO_W-1:0]  sb;
    logic [GEO_W-1:0]  room;
    logic [LINE_W:0]   set_mask_w;
    logic [LINE_W:0]   ways_m1_w;
    logic [TAG_W-1:0]  shifted;
    logic [LINE_W-1:0] set_idx;
    logic [SH_W-1:0]   tag_shift;

    always_comb
    begin
        wb         = (GEO_W'(way_bits_reg) > GEO_LIM) ? GEO_LIM : GEO_W'(way_bits_reg);
        room       = GEO_LIM - wb;
        sb         = (GEO_W'(set_bits_reg) > room) ? room : GEO_W'(set_bits_reg);
        set_mask_w = ((LINE_W + 1)'(1) << sb) - (LINE_W + 1)'(1);
        ways_m1_w  = ((LINE_W + 1)'(1) << wb) - (LINE_W + 1)'(1);
        shifted    = addr_q_reg >> block_bits_reg;
        set_idx    = shifted[LINE_W-1:0] & set_mask_w[LINE_W-1:0];
        tag_shift  = SH_W'(block_bits_reg) + SH_W'(sb);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_q_reg <= req_address[TAG_W-1:0];
            wr_q_reg   <= req_is_write;
        end
        if (cmd.setup)
        begin
            tag_reg     <= addr_q_reg >> tag_shift;
            base_reg    <= (set_idx << wb) & LINE_MASK;
            ways_m1_reg <= ways_m1_w[LINE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_cnt_reg <= '0;
        end
        else if (cmd.setup)
        begin
            way_cnt_reg <= '0;
        end
        else if (cmd.issue)
        begin
            way_cnt_reg <= way_cnt_reg + 1'b1;
        end
    end

    // Tag and stamp memories with registered read data.
    logic [TAG_W-1:0]           tag_mem   [LINE_COUNT];
    logic [sac_pkg::CNT_W-1:0]  stamp_mem [LINE_COUNT];
    logic [LINE_COUNT-1:0]      valid_reg;

    logic [TAG_W-1:0]           tag_rd_reg;
    logic [sac_pkg::CNT_W-1:0]  stamp_rd_reg;
    logic [LINE_W-1:0]          eval_line_reg;
    logic                       eval_first_reg;
    logic                       eval_vld_reg;
    logic [LINE_W-1:0]          rd_line;

    assign rd_line = (base_reg + way_cnt_reg) & LINE_MASK;

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            tag_rd_reg     <= tag_mem[rd_line];
            stamp_rd_reg   <= stamp_mem[rd_line];
            eval_line_reg  <= rd_line;
            eval_first_reg <= (way_cnt_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_vld_reg <= 1'b0;
        end
        else
        begin
            eval_vld_reg <= cmd.issue;
        end
    end

    // Scan results: first hit, first free way and oldest way.
    logic                       hit_found_reg,  hit_found_next;
    logic                       free_found_reg, free_found_next;
    logic [LINE_W-1:0]          hit_line_reg,   hit_line_next;
    logic [LINE_W-1:0]          free_line_reg,  free_line_next;
    logic [LINE_W-1:0]          victim_line_reg, victim_line_next;
    logic [sac_pkg::CNT_W-1:0]  victim_stamp_reg, victim_stamp_next;
    logic                       line_vld;

    assign line_vld = valid_reg[eval_line_reg];

    always_comb
    begin
        hit_found_next    = hit_found_reg;
        free_found_next   = free_found_reg;
        hit_line_next     = hit_line_reg;
        free_line_next    = free_line_reg;
        victim_line_next  = victim_line_reg;
        victim_stamp_next = victim_stamp_reg;
        if (cmd.setup)
        begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end
        else if (eval_vld_reg)
        begin
            if (line_vld)
            begin
                if ((tag_rd_reg == tag_reg) && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_line_next  = eval_line_reg;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_line_next  = eval_line_reg;
            end
            // The first way seeds the oldest-way search; a later way only
            // displaces it when strictly older, so ties keep the lower way.
            if (eval_first_reg)
            begin
                victim_line_next  = eval_line_reg;
                victim_stamp_next = stamp_rd_reg;
            end
            else if (line_vld && (stamp_rd_reg < victim_stamp_reg))
            begin
                victim_line_next  = eval_line_reg;
                victim_stamp_next = stamp_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_line_reg     <= hit_line_next;
        free_line_reg    <= free_line_next;
        victim_line_reg  <= victim_line_next;
        victim_stamp_reg <= victim_stamp_next;
    end

    // Commit: memory update, counters and result register.
    logic [LINE_W-1:0]         commit_line;
    logic [sac_pkg::CNT_W-1:0] clock_reg;
    logic [sac_pkg::CNT_W-1:0] hits_reg;
    logic [sac_pkg::CNT_W-1:0] misses_reg;
    logic [sac_pkg::CNT_W-1:0] writes_reg;
    logic                      out_valid_reg;
    logic                      was_hit_reg;

    assign commit_line = hit_found_reg  ? hit_line_reg :
                         free_found_reg ? free_line_reg : victim_line_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (!hit_found_reg)
            begin
                tag_mem[commit_line] <= tag_reg;
            end
            if (!hit_found_reg || use_lru_reg)
            begin
                stamp_mem[commit_line] <= clock_reg;
            end
            was_hit_reg <= hit_found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            clock_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            writes_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (hit_found_reg)
                begin
                    hits_reg <= sac_pkg::sat_inc(hits_reg);
                end
                else
                begin
                    misses_reg             <= sac_pkg::sat_inc(misses_reg);
                    valid_reg[commit_line] <= 1'b1;
                end
                if (wr_q_reg)
                begin
                    writes_reg <= sac_pkg::sat_inc(writes_reg);
                end
                clock_reg     <= sac_pkg::sat_inc(clock_reg);
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The counters only move at a commit, which needs the result slot free,
    // so they always hold the totals of the result on offer.
    assign rsp_valid       = out_valid_reg;
    assign rsp_was_hit     = was_hit_reg;
    assign rsp_hit_total   = hits_reg;
    assign rsp_miss_total  = misses_reg;
    assign rsp_write_total = writes_reg;

    assign sts.last_way = (way_cnt_reg == ways_m1_reg);
    assign sts.out_free = !out_valid_reg || rsp_ready;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || rsp_ready))
        else $error("commit while the result register is still occupied");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_miss_fills_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_found_reg) |=> valid_reg[$past(commit_line)])
        else $error("miss did not validate the filled line");

endmodule

// File: test/set_assoc_cache_lru_fifo_tb.sv
// ============================================================================
// Set-associative cache testbench
// Drives access beats into the tag cache under a series of cache geometries
// and replacement policies, predicts every result with a behavioural copy of
// the tag, valid and stamp stores, and checks each result beat field by field.
// ============================================================================
module set_assoc_cache_lru_fifo_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Widths taken from the shared package.
    localparam int ADDR_IN_W  = sac_pkg::ADDR_IN_W;
    localparam int CNT_W      = sac_pkg::CNT_W;
    localparam int CFG_IDX_W  = sac_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sac_pkg::CFG_DATA_W;
    localparam int BLOCK_W    = sac_pkg::BLOCK_W;
    localparam int SETB_W     = sac_pkg::SETB_W;
    localparam int WAYB_W     = sac_pkg::WAYB_W;

    // The lines in the cache: the predictor clamps the geometry against this.
    localparam int LINES_LOG2 = 6;
    localparam int LINE_COUNT = 1 << LINES_LOG2;

    // Cycles without any beat on either channel before the run is abandoned.
    // The slowest access scans 64 ways, and neither it, a phase change nor a long
    // run of receiver stalls comes near the limit.
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [ADDR_IN_W-1:0] addr;
        logic                 wr;
    } access_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] writes;
    } outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sac_req_if req_ch ();
    sac_rsp_if rsp_ch ();

    set_assoc_cache_lru_fifo u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state. The stores mirror the cache lines; line number is the
    // set times the way count plus the way. The register copies are updated
    // whenever the testbench writes a register, which only happens while the
    // cache is idle.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]   line_tag   [LINE_COUNT];
    logic               line_used  [LINE_COUNT];
    logic [CNT_W-1:0]   line_stamp [LINE_COUNT];
    logic [CNT_W-1:0]   access_clock;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   write_count;

    logic [BLOCK_W-1:0] block_bits_r;
    logic [SETB_W-1:0]  set_bits_r;
    logic [WAYB_W-1:0]  way_bits_r;
    logic               lru_on;

    // Stimulus queues and run bookkeeping.
    access_t  access_queue  [$];
    outcome_t outcome_queue [$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       error_count;
    int       results_checked;
    int       hits_checked;
    int       phase_count;
    int       quiet_cycles;

    // Counters at their top value stay there.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // The effective log2 of the ways: too many ways is clamped to the cache size.
    function automatic int eff_way_log2();
        return (way_bits_r > LINES_LOG2) ? LINES_LOG2 : int'(way_bits_r);
    endfunction

    // Cycles to let pass once the last result has gone: one full access plus margin.
    function automatic int settle_cycles();
        return (1 << eff_way_log2()) + 8;
    endfunction

    // Looks one access up in the predicted cache, updates the stores and the
    // totals, and returns the result beat that the cache must produce.
    function automatic outcome_t cache_lookup(input access_t acc);
        int               wb;
        int               sb;
        int               ways;
        int               shift;
        int               base;
        int               ln;
        int               hit_way;
        int               free_way;
        int               victim;
        int               fill;
        logic [CNT_W-1:0] set_idx;
        logic [CNT_W-1:0] tag;
        outcome_t         res;

        wb = eff_way_log2();
        // The set bits only get what the ways leave of the cache.
        sb = (int'(set_bits_r) > LINES_LOG2 - wb) ? LINES_LOG2 - wb : int'(set_bits_r);
        ways = 1 << wb;
        shift = int'(block_bits_r) + sb;
        set_idx = (acc.addr >> block_bits_r) & ((48'd1 << sb) - 48'd1);
        tag = acc.addr >> shift;
        base = int'(set_idx) * ways;
        hit_way = -1;
        free_way = -1;
        victim = 0;

        // The first matching way hits; the oldest valid way is the victim,
        // with a tie left on the lower way; the first empty way is the fill.
        for (int w = 0; w < ways; w++)
        begin
            ln = (base + w) % LINE_COUNT;
            if (line_used[ln])
            begin
                if (line_tag[ln] == tag && hit_way < 0)
                    hit_way = w;
                if (line_stamp[ln] < line_stamp[(base + victim) % LINE_COUNT])
                    victim = w;
            end
            else if (free_way < 0)
            begin
                free_way = w;
            end
        end

        if (hit_way >= 0)
        begin
            ln = (base + hit_way) % LINE_COUNT;
            // Only LRU renews the stamp; FIFO keeps the stamp of the fill.
            if (lru_on)
                line_stamp[ln] = access_clock;
            hit_count = bump(hit_count);
        end
        else
        begin
            fill = (free_way >= 0) ? free_way : victim;
            ln = (base + fill) % LINE_COUNT;
            line_tag[ln] = tag;
            line_stamp[ln] = access_clock;
            line_used[ln] = 1'b1;
            miss_count = bump(miss_count);
        end
        if (acc.wr)
            write_count = bump(write_count);
        access_clock = bump(access_clock);

        res.hit = (hit_way >= 0);
        res.hits = hit_count;
        res.misses = miss_count;
        res.writes = write_count;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A beat that has been offered stays on the channel until
    // it is taken. When the channel is free, the next pending access is
    // offered unless the sender is chosen to idle this cycle. The predictor
    // runs on the accepting edge, so its state always follows the cache.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.address <= '0;
            req_ch.is_write <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                outcome_queue.push_back(cache_lookup({req_ch.address, req_ch.is_write}));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (access_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.address <= access_queue[0].addr;
                    req_ch.is_write <= access_queue[0].wr;
                    void'(access_queue.pop_front());
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Every result beat is held against the oldest prediction;
    // ready is dropped at random to stall the cache on its output.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (outcome_queue.size() == 0)
                begin
                    $display("%0t: result beat with no access outstanding, hit %0d",
                             $time, rsp_ch.was_hit);
                    error_count++;
                end
                else
                begin
                    check_field("was_hit", CNT_W'(outcome_queue[0].hit),
                                CNT_W'(rsp_ch.was_hit));
                    check_field("hit_total", outcome_queue[0].hits, rsp_ch.hit_total);
                    check_field("miss_total", outcome_queue[0].misses, rsp_ch.miss_total);
                    check_field("write_total", outcome_queue[0].writes, rsp_ch.write_total);
                    if (outcome_queue[0].hit)
                        hits_checked++;
                    results_checked++;
                    void'(outcome_queue.pop_front());
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run in which no beat moves for too long has hung.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d accesses pending, %0d results owed",
                         $time, quiet_cycles, access_queue.size(), outcome_queue.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------

    // Writes one register at a rising edge and keeps the predictor's copy in step.
    task automatic write_reg(input sac_pkg::cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            sac_pkg::CFG_BLOCK_BITS: block_bits_r = val[BLOCK_W-1:0];
            sac_pkg::CFG_SET_BITS:   set_bits_r = val[SETB_W-1:0];
            sac_pkg::CFG_WAY_BITS:   way_bits_r = val[WAYB_W-1:0];
            sac_pkg::CFG_USE_LRU:    lru_on = val[0];
            default:                 ;
        endcase
    endtask

    // Waits until every access has been taken and answered, then lets the
    // cache finish whatever bookkeeping follows its last result.
    task automatic wait_drained();
        while (access_queue.size() > 0 || outcome_queue.size() > 0 || req_ch.valid)
            @(negedge clk);
        repeat (settle_cycles()) @(negedge clk);
    endtask

    task automatic push_access(input logic [ADDR_IN_W-1:0] addr, input logic wr);
        access_t acc;

        acc.addr = addr;
        acc.wr = wr;
        access_queue.push_back(acc);
    endtask

    // Directed opening sequence for the reset geometry: 64-byte blocks,
    // 16 sets, 4 ways, LRU. Set 0 tags are the address bits above bit 9.
    task automatic push_directed();
        push_access(48'h0, 1'b0);                   // cold miss
        push_access(48'h0, 1'b1);                   // same block, write hit
        push_access(48'h3F, 1'b0);                  // last byte of the block hits
        push_access(48'hFFFF_FFFF_FFFF, 1'b1);      // top of the address space
        push_access(48'hFFFF_FFFF_FFC0, 1'b0);      // same block from its start
        push_access(48'h400, 1'b0);                 // fill the rest of set 0
        push_access(48'h800, 1'b1);
        push_access(48'hC00, 1'b0);
        push_access(48'h0, 1'b0);                   // renew tag 0 under LRU
        push_access(48'h1000, 1'b0);                // set full: evicts tag 1
        push_access(48'h400, 1'b1);                 // tag 1 gone again: evicts tag 2
        push_access(48'h0, 1'b0);                   // tag 0 survived both
        push_access(48'hC00, 1'b0);
        push_access(48'h800, 1'b0);                 // evicted, misses
        push_access(48'hAAAA_AAAA_AAAA, 1'b1);      // alternating address bits
        push_access(48'h5555_5555_5555, 1'b0);
        push_access(48'hAAAA_AAAA_AAAA, 1'b0);
        push_access(48'h8000_0000_0000, 1'b1);      // only the top bit
    endtask

    // One phase: a geometry and policy, a pattern of idling and a batch of
    // random accesses. Most accesses come from a small pool of blocks so that
    // sets fill up, hit and replace; the rest are wholly random addresses.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] blk, input logic [CFG_DATA_W-1:0] setb,
                             input logic [CFG_DATA_W-1:0] wayb, input logic lru,
                             input int send_idle, input int stall, input int n_rand,
                             input bit with_directed);
        logic [ADDR_IN_W-1:0] pool [];
        logic [ADDR_IN_W-1:0] offset_mask;
        logic [ADDR_IN_W-1:0] addr;

        wait_drained();
        write_reg(sac_pkg::CFG_BLOCK_BITS, blk);
        write_reg(sac_pkg::CFG_SET_BITS, setb);
        write_reg(sac_pkg::CFG_WAY_BITS, wayb);
        write_reg(sac_pkg::CFG_USE_LRU, {{(CFG_DATA_W-1){1'b0}}, lru});
        @(posedge clk);
        cfg_en <= 1'b0;

        @(negedge clk);
        phase_count++;
        send_idle_pct = send_idle;
        recv_stall_pct = stall;

        pool = new[$urandom_range(40, 4)];
        foreach (pool[i])
            pool[i] = ADDR_IN_W'({$urandom(), $urandom()});
        offset_mask = (48'd1 << blk) - 48'd1;

        if (with_directed)
            push_directed();
        for (int n = 0; n < n_rand; n++)
        begin
            if ($urandom_range(99) < 85)
                addr = (pool[$urandom_range(pool.size() - 1)] & ~offset_mask) |
                       (ADDR_IN_W'({$urandom(), $urandom()}) & offset_mask);
            else
                addr = ADDR_IN_W'({$urandom(), $urandom()});
            push_access(addr, 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Every input is known from time zero, while reset is held low.
        rst_n = 1'b0;
        cfg_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.address = '0;
        req_ch.is_write = 1'b0;
        rsp_ch.ready = 1'b0;

        foreach (line_used[i])
        begin
            line_used[i] = 1'b0;
            line_tag[i] = '0;
            line_stamp[i] = '0;
        end
        access_clock = '0;
        hit_count = '0;
        miss_count = '0;
        write_count = '0;
        block_bits_r = sac_pkg::BLOCK_BITS_RST;
        set_bits_r = sac_pkg::SET_BITS_RST;
        way_bits_r = sac_pkg::WAY_BITS_RST;
        lru_on = sac_pkg::USE_LRU_RST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        results_checked = 0;
        hits_checked = 0;
        phase_count = 0;
        quiet_cycles = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry with the directed sequence, no idling on either side.
        run_phase(5'd6, 5'd4, 5'd2, 1'b1, 0, 0, 70, 1'b1);
        // Fully associative, 64 ways, byte blocks: the slowest scan.
        run_phase(5'd0, 5'd0, 5'd6, 1'b1, 0, 0, 30, 1'b0);
        // Direct mapped with 64 sets, FIFO, a sender that idles often.
        run_phase(5'd16, 5'd6, 5'd0, 1'b0, 57, 0, 90, 1'b0);
        // Register fields at their tops: the ways clamp to 64 and leave no set bits.
        run_phase(5'd31, 5'd7, 5'd7, 1'b0, 0, 57, 30, 1'b0);
        // Eight sets of eight ways under FIFO, both sides idling.
        run_phase(5'd4, 5'd3, 5'd3, 1'b0, 37, 37, 80, 1'b0);
        // Four sets of four ways under LRU, both sides idling.
        run_phase(5'd2, 5'd2, 5'd2, 1'b1, 37, 37, 80, 1'b0);
        // More set bits than the ways leave room for, FIFO, idle sender.
        run_phase(5'd8, 5'd7, 5'd5, 1'b0, 57, 0, 50, 1'b0);
        // Two-way sets under LRU with a stalling receiver.
        run_phase(5'd5, 5'd5, 5'd1, 1'b1, 0, 57, 70, 1'b0);

        wait_drained();

        $display("Checked %0d access results across %0d cache geometries and policies,",
                 results_checked, phase_count);
        $display("of which %0d were hits, with %0d mismatches found.",
                 hits_checked, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
